// ----- rtl/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants for the box point sampler: default widths, register
// indexes, face codes and queue sizing.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int RAND_WIDTH_DEFAULT  = 16;

   localparam int QUEUE_DEPTH = 4;

   localparam int REG_INDEX_WIDTH = 3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_MIN_X        = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_MIN_Y        = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_MIN_Z        = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_MAX_X        = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_MAX_Y        = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_MAX_Z        = 3'd5;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_SURFACE_MODE = 3'd6;

   localparam int FACE_WIDTH = 3;
   localparam logic [FACE_WIDTH-1:0] FACE_MIN_Z  = 3'd0;
   localparam logic [FACE_WIDTH-1:0] FACE_MAX_Z  = 3'd1;
   localparam logic [FACE_WIDTH-1:0] FACE_MIN_Y  = 3'd2;
   localparam logic [FACE_WIDTH-1:0] FACE_MAX_Y  = 3'd3;
   localparam logic [FACE_WIDTH-1:0] FACE_MIN_X  = 3'd4;
   localparam logic [FACE_WIDTH-1:0] FACE_MAX_X  = 3'd5;
   localparam logic [FACE_WIDTH-1:0] FACE_VOLUME = 3'd6;

endpackage

// ----- rtl/box_point_sampler_core.sv -----
// Throughput: one word per cycle unless rsp_tready stalls it; a 4-entry queue
// decouples the input stage from the four-stage multiply/compare datapath.
// Reset: synchronous, active high; clears all valid state and the queue and
// loads the unit box [0,1] in volume mode.
// ----------------------------------------------------------------------------
// box_point_sampler_core
// Uniform random point inside or on the surface of an axis-aligned box.
// ----------------------------------------------------------------------------
module box_point_sampler_core #(
   parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = bps_pkg::FRAC_BITS_DEFAULT,
   parameter int RAND_WIDTH  = bps_pkg::RAND_WIDTH_DEFAULT,
   parameter int REQ_WIDTH   = ((4 * RAND_WIDTH + 7) / 8) * 8,
   parameter int RSP_WIDTH   = ((3 * COORD_WIDTH + 7) / 8) * 8,
   parameter int CSR_STRIDE  = (COORD_WIDTH > 32) ? 8 : 4,
   parameter int CSR_DATA_W  = (COORD_WIDTH > 32) ? 64 : 32,
   parameter int CSR_ADDR_W  = $clog2(7 * CSR_STRIDE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pick_fraction, rand_a, rand_b, rand_c
   input  logic [REQ_WIDTH-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // point_x, point_y, point_z
   output logic [RSP_WIDTH-1:0]  rsp_tdata,
   // face_index, degenerate
   output logic [3:0]            rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ENTRY_W = 4 * RAND_WIDTH + 3 * COORD_WIDTH + 1;

   logic [COORD_WIDTH-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
   logic                   surface_mode;
   logic                   f_valid, f_ready, q_valid, q_ready;
   logic [ENTRY_W-1:0]     f_entry, q_entry;
   logic [COORD_WIDTH-1:0] point_x, point_y, point_z;
   logic [bps_pkg::FACE_WIDTH-1:0] face_index;
   logic                   degenerate;

   bps_csr #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .DATA_WIDTH (CSR_DATA_W),
      .ADDR_WIDTH (CSR_ADDR_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .min_x       (min_x),
      .min_y       (min_y),
      .min_z       (min_z),
      .max_x       (max_x),
      .max_y       (max_y),
      .max_z       (max_z),
      .surface_mode(surface_mode)
   );

   bps_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .RAND_WIDTH (RAND_WIDTH),
      .ENTRY_WIDTH(ENTRY_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .pick_fraction(req_tdata[RAND_WIDTH-1:0]),
      .rand_a       (req_tdata[2*RAND_WIDTH-1:RAND_WIDTH]),
      .rand_b       (req_tdata[3*RAND_WIDTH-1:2*RAND_WIDTH]),
      .rand_c       (req_tdata[4*RAND_WIDTH-1:3*RAND_WIDTH]),
      .min_x        (min_x),
      .min_y        (min_y),
      .min_z        (min_z),
      .max_x        (max_x),
      .max_y        (max_y),
      .max_z        (max_z),
      .surface_mode (surface_mode),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_entry    (f_entry)
   );

   bps_queue #(
      .ENTRY_WIDTH(ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .in_entry (f_entry),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_entry(q_entry)
   );

   bps_back #(
      .COORD_WIDTH(COORD_WIDTH),
      .RAND_WIDTH (RAND_WIDTH),
      .ENTRY_WIDTH(ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_entry  (q_entry),
      .min_x     (min_x),
      .min_y     (min_y),
      .min_z     (min_z),
      .max_x     (max_x),
      .max_y     (max_y),
      .max_z     (max_z),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .point_x   (point_x),
      .point_y   (point_y),
      .point_z   (point_z),
      .face_index(face_index),
      .degenerate(degenerate)
   );

   assign rsp_tdata = RSP_WIDTH'({point_z, point_y, point_x});
   assign rsp_tuser = {degenerate, face_index};

endmodule

// ----- rtl/bps_csr.sv -----
// ----------------------------------------------------------------------------
// bps_csr
// Configuration registers: box corners and sampling mode, written and read
// over the register port.
// ----------------------------------------------------------------------------
module bps_csr #(
   parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = bps_pkg::FRAC_BITS_DEFAULT,
   parameter int DATA_WIDTH  = 32,
   parameter int ADDR_WIDTH  = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [DATA_WIDTH-1:0]  csr_pwdata,
   output logic [DATA_WIDTH-1:0]  csr_prdata,
   output logic                   csr_pready,
   output logic [COORD_WIDTH-1:0] min_x,
   output logic [COORD_WIDTH-1:0] min_y,
   output logic [COORD_WIDTH-1:0] min_z,
   output logic [COORD_WIDTH-1:0] max_x,
   output logic [COORD_WIDTH-1:0] max_y,
   output logic [COORD_WIDTH-1:0] max_z,
   output logic                   surface_mode
);

   localparam logic [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1) << FRAC_BITS;

   logic [COORD_WIDTH-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic [COORD_WIDTH-1:0] max_x_ff, max_y_ff, max_z_ff;
   logic                   surface_mode_ff;
   logic [COORD_WIDTH-1:0] wdata;
   logic [bps_pkg::REG_INDEX_WIDTH-1:0] index;
   logic                   write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = csr_paddr[ADDR_WIDTH-1 -: bps_pkg::REG_INDEX_WIDTH];
   assign wdata      = csr_pwdata[COORD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff        <= '0;
         min_y_ff        <= '0;
         min_z_ff        <= '0;
         max_x_ff        <= ONE;
         max_y_ff        <= ONE;
         max_z_ff        <= ONE;
         surface_mode_ff <= 1'b0;
      end else if (write_en) begin
         case (index)
            bps_pkg::REG_MIN_X:        min_x_ff        <= wdata;
            bps_pkg::REG_MIN_Y:        min_y_ff        <= wdata;
            bps_pkg::REG_MIN_Z:        min_z_ff        <= wdata;
            bps_pkg::REG_MAX_X:        max_x_ff        <= wdata;
            bps_pkg::REG_MAX_Y:        max_y_ff        <= wdata;
            bps_pkg::REG_MAX_Z:        max_z_ff        <= wdata;
            bps_pkg::REG_SURFACE_MODE: surface_mode_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         bps_pkg::REG_MIN_X:        csr_prdata = DATA_WIDTH'(min_x_ff);
         bps_pkg::REG_MIN_Y:        csr_prdata = DATA_WIDTH'(min_y_ff);
         bps_pkg::REG_MIN_Z:        csr_prdata = DATA_WIDTH'(min_z_ff);
         bps_pkg::REG_MAX_X:        csr_prdata = DATA_WIDTH'(max_x_ff);
         bps_pkg::REG_MAX_Y:        csr_prdata = DATA_WIDTH'(max_y_ff);
         bps_pkg::REG_MAX_Z:        csr_prdata = DATA_WIDTH'(max_z_ff);
         bps_pkg::REG_SURFACE_MODE: csr_prdata = DATA_WIDTH'(surface_mode_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign min_x        = min_x_ff;
   assign min_y        = min_y_ff;
   assign min_z        = min_z_ff;
   assign max_x        = max_x_ff;
   assign max_y        = max_y_ff;
   assign max_z        = max_z_ff;
   assign surface_mode = surface_mode_ff;

endmodule

// ----- rtl/bps_front.sv -----
// ----------------------------------------------------------------------------
// bps_front
// Input stage: accept a word, take the side lengths of the box and the
// sampling mode, and hand the packed entry to the queue.
// ----------------------------------------------------------------------------
module bps_front #(
   parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEFAULT,
   parameter int RAND_WIDTH  = bps_pkg::RAND_WIDTH_DEFAULT,
   parameter int ENTRY_WIDTH = 4 * RAND_WIDTH + 3 * COORD_WIDTH + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [RAND_WIDTH-1:0]  pick_fraction,
   input  logic [RAND_WIDTH-1:0]  rand_a,
   input  logic [RAND_WIDTH-1:0]  rand_b,
   input  logic [RAND_WIDTH-1:0]  rand_c,
   input  logic [COORD_WIDTH-1:0] min_x,
   input  logic [COORD_WIDTH-1:0] min_y,
   input  logic [COORD_WIDTH-1:0] min_z,
   input  logic [COORD_WIDTH-1:0] max_x,
   input  logic [COORD_WIDTH-1:0] max_y,
   input  logic [COORD_WIDTH-1:0] max_z,
   input  logic                   surface_mode,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [ENTRY_WIDTH-1:0] out_entry
);

   logic                   valid_ff, valid_in;
   logic [ENTRY_WIDTH-1:0] entry_ff, entry_in;
   logic [COORD_WIDTH-1:0] len_x, len_y, len_z;
   logic                   accept;

   // clamp reversed axes to zero length
   assign len_x = ($signed(max_x) >= $signed(min_x)) ? max_x - min_x : '0;
   assign len_y = ($signed(max_y) >= $signed(min_y)) ? max_y - min_y : '0;
   assign len_z = ($signed(max_z) >= $signed(min_z)) ? max_z - min_z : '0;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign valid_in = accept || (valid_ff && !out_ready);
   assign entry_in = {surface_mode, len_z, len_y, len_x,
                      rand_c, rand_b, rand_a, pick_fraction};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

// ----- rtl/bps_queue.sv -----
// ----------------------------------------------------------------------------
// bps_queue
// Short first-in first-out queue between the input stage and the datapath.
// ----------------------------------------------------------------------------
module bps_queue #(
   parameter int ENTRY_WIDTH = 161
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [ENTRY_WIDTH-1:0] in_entry,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [ENTRY_WIDTH-1:0] out_entry
);

   localparam int DEPTH = bps_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [ENTRY_WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count missed a push");
`endif

endmodule

// ----- rtl/bps_back.sv -----
// ----------------------------------------------------------------------------
// bps_back
// Datapath: face areas and offsets, cumulative areas, scaled pick target,
// face choice and final point into the output register.
// ----------------------------------------------------------------------------
module bps_back #(
   parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEFAULT,
   parameter int RAND_WIDTH  = bps_pkg::RAND_WIDTH_DEFAULT,
   parameter int ENTRY_WIDTH = 4 * RAND_WIDTH + 3 * COORD_WIDTH + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [ENTRY_WIDTH-1:0]            in_entry,
   input  logic [COORD_WIDTH-1:0]            min_x,
   input  logic [COORD_WIDTH-1:0]            min_y,
   input  logic [COORD_WIDTH-1:0]            min_z,
   input  logic [COORD_WIDTH-1:0]            max_x,
   input  logic [COORD_WIDTH-1:0]            max_y,
   input  logic [COORD_WIDTH-1:0]            max_z,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [COORD_WIDTH-1:0]            point_x,
   output logic [COORD_WIDTH-1:0]            point_y,
   output logic [COORD_WIDTH-1:0]            point_z,
   output logic [bps_pkg::FACE_WIDTH-1:0]    face_index,
   output logic                              degenerate
);

   localparam int CW    = COORD_WIDTH;
   localparam int RW    = RAND_WIDTH;
   localparam int AW    = 2 * CW;
   localparam int CUM_W = 2 * CW + 3;
   localparam int TGT_W = CUM_W + RW;
   localparam int PW    = CW + RW;

   // unpack queue entry
   logic [RW-1:0] e_pick, e_ra, e_rb, e_rc;
   logic [CW-1:0] e_lx, e_ly, e_lz;
   logic          e_surface;

   assign {e_surface, e_lz, e_ly, e_lx, e_rc, e_rb, e_ra, e_pick} = in_entry;

   logic ready1, ready2, ready3, ready4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1: products
   logic [AW-1:0] axy_ff, axz_ff, ayz_ff, axy_in, axz_in, ayz_in;
   logic [PW-1:0] p_xa, p_yb, p_ya, p_zc, p_zb;
   logic [CW-1:0] off_xa_ff, off_yb_ff, off_ya_ff, off_zc_ff, off_zb_ff;
   logic [RW-1:0] pick1_ff;
   logic          surf1_ff;

   assign axy_in = AW'(e_lx) * AW'(e_ly);
   assign axz_in = AW'(e_lx) * AW'(e_lz);
   assign ayz_in = AW'(e_ly) * AW'(e_lz);
   assign p_xa   = PW'(e_ra) * PW'(e_lx);
   assign p_yb   = PW'(e_rb) * PW'(e_ly);
   assign p_ya   = PW'(e_ra) * PW'(e_ly);
   assign p_zc   = PW'(e_rc) * PW'(e_lz);
   assign p_zb   = PW'(e_rb) * PW'(e_lz);

   always_ff @(posedge clock) begin
      if (ready1) begin
         axy_ff    <= axy_in;
         axz_ff    <= axz_in;
         ayz_ff    <= ayz_in;
         off_xa_ff <= p_xa[PW-1:RW];
         off_yb_ff <= p_yb[PW-1:RW];
         off_ya_ff <= p_ya[PW-1:RW];
         off_zc_ff <= p_zc[PW-1:RW];
         off_zb_ff <= p_zb[PW-1:RW];
         pick1_ff  <= e_pick;
         surf1_ff  <= e_surface;
      end
   end

   // stage 2: cumulative areas and placed coordinates
   logic [CUM_W-1:0] c1_w, c3_w;
   logic [CUM_W-1:0] cum_in [5];
   logic [CUM_W-1:0] cum2_ff [5];
   logic [CUM_W-1:0] total_in, total_ff;
   logic [CW-1:0]    xa_ff, yb_ff, ya_ff, zc_ff, zb_ff;
   logic [RW-1:0]    pick2_ff;
   logic             surf2_ff;

   assign c1_w      = CUM_W'(axy_ff) << 1;
   assign c3_w      = c1_w + (CUM_W'(axz_ff) << 1);
   assign cum_in[0] = CUM_W'(axy_ff);
   assign cum_in[1] = c1_w;
   assign cum_in[2] = c1_w + CUM_W'(axz_ff);
   assign cum_in[3] = c3_w;
   assign cum_in[4] = c3_w + CUM_W'(ayz_ff);
   assign total_in  = c3_w + (CUM_W'(ayz_ff) << 1);

   always_ff @(posedge clock) begin
      if (ready2) begin
         cum2_ff  <= cum_in;
         total_ff <= total_in;
         xa_ff    <= min_x + off_xa_ff;
         yb_ff    <= min_y + off_yb_ff;
         ya_ff    <= min_y + off_ya_ff;
         zc_ff    <= min_z + off_zc_ff;
         zb_ff    <= min_z + off_zb_ff;
         pick2_ff <= pick1_ff;
         surf2_ff <= surf1_ff;
      end
   end

   // stage 3: pick target
   logic [TGT_W-1:0] target_in, target_ff;
   logic [CUM_W-1:0] cum3_ff [5];
   logic [CW-1:0]    xa3_ff, yb3_ff, ya3_ff, zc3_ff, zb3_ff;
   logic             surf3_ff, zero3_ff;

   assign target_in = TGT_W'(total_ff) * TGT_W'(pick2_ff);

   always_ff @(posedge clock) begin
      if (ready3) begin
         target_ff <= target_in;
         zero3_ff  <= total_ff == '0;
         cum3_ff   <= cum2_ff;
         xa3_ff    <= xa_ff;
         yb3_ff    <= yb_ff;
         ya3_ff    <= ya_ff;
         zc3_ff    <= zc_ff;
         zb3_ff    <= zb_ff;
         surf3_ff  <= surf2_ff;
      end
   end

   // stage 4: face choice and point
   logic [4:0]                     hit;
   logic [bps_pkg::FACE_WIDTH-1:0] face_in, face_ff, pick_face;
   logic [CW-1:0]                  x_in, y_in, z_in, x_ff, y_ff, z_ff;
   logic                           degen_in, degen_ff;

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         hit[k] = target_ff < {cum3_ff[k], {RW{1'b0}}};
      end
      if (hit[0]) begin
         pick_face = bps_pkg::FACE_MIN_Z;
      end else if (hit[1]) begin
         pick_face = bps_pkg::FACE_MAX_Z;
      end else if (hit[2]) begin
         pick_face = bps_pkg::FACE_MIN_Y;
      end else if (hit[3]) begin
         pick_face = bps_pkg::FACE_MAX_Y;
      end else if (hit[4]) begin
         pick_face = bps_pkg::FACE_MIN_X;
      end else begin
         pick_face = bps_pkg::FACE_MAX_X;
      end

      degen_in = 1'b0;
      if (!surf3_ff) begin
         face_in = bps_pkg::FACE_VOLUME;
      end else if (zero3_ff) begin
         face_in  = bps_pkg::FACE_MIN_Z;
         degen_in = 1'b1;
      end else begin
         face_in = pick_face;
      end

      case (face_in)
         bps_pkg::FACE_MIN_Z, bps_pkg::FACE_MAX_Z: begin
            x_in = xa3_ff;
            y_in = yb3_ff;
            z_in = (face_in == bps_pkg::FACE_MAX_Z) ? max_z : min_z;
         end
         bps_pkg::FACE_MIN_Y, bps_pkg::FACE_MAX_Y: begin
            x_in = xa3_ff;
            y_in = (face_in == bps_pkg::FACE_MAX_Y) ? max_y : min_y;
            z_in = zb3_ff;
         end
         bps_pkg::FACE_MIN_X, bps_pkg::FACE_MAX_X: begin
            x_in = (face_in == bps_pkg::FACE_MAX_X) ? max_x : min_x;
            y_in = ya3_ff;
            z_in = zb3_ff;
         end
         default: begin
            x_in = xa3_ff;
            y_in = yb3_ff;
            z_in = zc3_ff;
         end
      endcase

      if (degen_in) begin
         x_in = min_x;
         y_in = min_y;
         z_in = min_z;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         face_ff  <= face_in;
         degen_ff <= degen_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
      end
   end

   // valid chain
   assign ready4   = !v4_ff || out_ready;
   assign ready3   = !v3_ff || ready4;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   assign out_valid  = v4_ff;
   assign point_x    = x_ff;
   assign point_y    = y_ff;
   assign point_z    = z_ff;
   assign face_index = face_ff;
   assign degenerate = degen_ff;

`ifndef NO_ASSERTIONS
   a_degen_face: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && degen_ff) |-> face_ff == bps_pkg::FACE_MIN_Z)
      else $error("degenerate result with a face other than min z");

   a_volume_clean: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && face_ff == bps_pkg::FACE_VOLUME) |-> !degen_ff)
      else $error("volume result flagged degenerate");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !ready4) |=> v3_ff && $stable(target_ff))
      else $error("stage three lost a word under stall");
`endif

endmodule

// ----- test/tb_box_point_sampler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_point_sampler_core
// Streams fraction words through the box point sampler under a series of box
// settings: unit box, full signed range, reversed and flat axes, volume and
// surface mode. Each result word is checked field by field against a local
// prediction of the sampled point, face and zero-area flag. Both stream sides
// idle at random; the register port is written and read back between phases.
// ----------------------------------------------------------------------------
module tb_box_point_sampler_core;
   import bps_pkg::*;

   localparam int REQ_W         = 64;
   localparam int RSP_W         = 96;
   localparam int CSR_AW        = 5;
   localparam int CSR_DW        = 32;
   localparam int CSR_STRIDE    = 4;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_WORDS   = 160;

   typedef struct packed {
      logic [15:0] rand_c;
      logic [15:0] rand_b;
      logic [15:0] rand_a;
      logic [15:0] pick;
   } sample_type;

   typedef struct packed {
      logic        degenerate;
      logic [2:0]  face;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } point_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [3:0]        rsp_tuser;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   logic signed [31:0] lo_x = 32'sh0;
   logic signed [31:0] lo_y = 32'sh0;
   logic signed [31:0] lo_z = 32'sh0;
   logic signed [31:0] hi_x = 32'sh0001_0000;
   logic signed [31:0] hi_y = 32'sh0001_0000;
   logic signed [31:0] hi_z = 32'sh0001_0000;
   logic               surface_on = 1'b0;

   sample_type pending_samples[$];
   point_type  expected_points[$];
   int      issued_count = 0;
   int      popped_count = 0;
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      req_gap_pct = 20;
   int      rsp_stall_pct = 20;
   int      req_gap_left = 0;
   int      rsp_stall_left = 0;

   box_point_sampler_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_box_point_sampler_core NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got_val,
                                  input logic [31:0] want_val);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got_val, want_val,
               cycle_count);
      mismatch_count++;
   endtask

   function automatic logic [31:0] side_length(logic signed [31:0] lo, logic signed [31:0] hi);
      return (hi >= lo) ? 32'(hi - lo) : 32'd0;
   endfunction

   function automatic logic [31:0] place_on_axis(logic [31:0] corner, logic [15:0] frac,
                                                 logic [31:0] len);
      logic [47:0] prod;
      prod = 48'(frac) * 48'(len);
      return corner + prod[47:16];
   endfunction

   function automatic point_type predict_point(sample_type s);
      point_type   p;
      logic [31:0] len_x, len_y, len_z;
      logic [95:0] area_xy, area_xz, area_yz, target;
      logic [95:0] cum [6];
      len_x = side_length(lo_x, hi_x);
      len_y = side_length(lo_y, hi_y);
      len_z = side_length(lo_z, hi_z);
      p.x = lo_x;
      p.y = lo_y;
      p.z = lo_z;
      p.face = FACE_VOLUME;
      p.degenerate = 1'b0;
      if (!surface_on) begin
         p.x = place_on_axis(lo_x, s.rand_a, len_x);
         p.y = place_on_axis(lo_y, s.rand_b, len_y);
         p.z = place_on_axis(lo_z, s.rand_c, len_z);
      end else begin
         area_xy = 96'(len_x) * 96'(len_y);
         area_xz = 96'(len_x) * 96'(len_z);
         area_yz = 96'(len_y) * 96'(len_z);
         cum[0] = area_xy;
         cum[1] = cum[0] + area_xy;
         cum[2] = cum[1] + area_xz;
         cum[3] = cum[2] + area_xz;
         cum[4] = cum[3] + area_yz;
         cum[5] = cum[4] + area_yz;
         if (cum[5] == '0) begin
            p.face = FACE_MIN_Z;
            p.degenerate = 1'b1;
         end else begin
            target = cum[5] * 96'(s.pick);
            p.face = FACE_MAX_X;
            // scan down so the lowest face that covers the target wins
            for (int k = 5; k >= 0; k--) begin
               if (target < (cum[k] << 16)) p.face = 3'(k);
            end
            case (p.face)
               FACE_MIN_Z, FACE_MAX_Z: begin
                  p.x = place_on_axis(lo_x, s.rand_a, len_x);
                  p.y = place_on_axis(lo_y, s.rand_b, len_y);
                  p.z = (p.face == FACE_MAX_Z) ? hi_z : lo_z;
               end
               FACE_MIN_Y, FACE_MAX_Y: begin
                  p.x = place_on_axis(lo_x, s.rand_a, len_x);
                  p.y = (p.face == FACE_MAX_Y) ? hi_y : lo_y;
                  p.z = place_on_axis(lo_z, s.rand_b, len_z);
               end
               default: begin
                  p.x = (p.face == FACE_MAX_X) ? hi_x : lo_x;
                  p.y = place_on_axis(lo_y, s.rand_a, len_y);
                  p.z = place_on_axis(lo_z, s.rand_b, len_z);
               end
            endcase
         end
      end
      return p;
   endfunction

   function automatic int random_gap(int pct);
      if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_points.insert(expected_points.size(),
                                   predict_point(sample_type'(req_tdata)));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_tdata <= pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_gap_left = random_gap(req_gap_pct);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      point_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_points.size() == 0) begin
               report_mismatch("word with no expectation", got.x, 32'd0);
            end else begin
               want = expected_points.pop_front();
               popped_count++;
               if (got.x !== want.x) report_mismatch("point_x", got.x, want.x);
               if (got.y !== want.y) report_mismatch("point_y", got.y, want.y);
               if (got.z !== want.z) report_mismatch("point_z", got.z, want.z);
               if (got.face !== want.face) begin
                  report_mismatch("face_index", 32'(got.face), 32'(want.face));
               end
               if (got.degenerate !== want.degenerate) begin
                  report_mismatch("degenerate", 32'(got.degenerate), 32'(want.degenerate));
               end
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_stall_left = random_gap(rsp_stall_pct);
            rsp_tready <= (rsp_stall_left == 0);
         end
      end
   end

   task automatic push_sample(input logic [15:0] pick, input logic [15:0] ra,
                              input logic [15:0] rb, input logic [15:0] rc);
      sample_type s;
      s = '{rand_c: rc, rand_b: rb, rand_a: ra, pick: pick};
      pending_samples.insert(pending_samples.size(), s);
      issued_count++;
   endtask

   task automatic drain_results();
      while (popped_count != issued_count) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] reg_index, input logic [31:0] value);
      logic [31:0] readback, want;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(reg_index * CSR_STRIDE);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      want = value;
      case (reg_index)
         REG_MIN_X: lo_x = value;
         REG_MIN_Y: lo_y = value;
         REG_MIN_Z: lo_z = value;
         REG_MAX_X: hi_x = value;
         REG_MAX_Y: hi_y = value;
         REG_MAX_Z: hi_z = value;
         REG_SURFACE_MODE: begin
            surface_on = value[0];
            want = {31'd0, value[0]};
         end
         default: ;
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== want) report_mismatch("register readback", readback, want);
   endtask

   task automatic apply_box(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                            input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz,
                            input logic surf);
      csr_write(REG_MIN_X, lx);
      csr_write(REG_MIN_Y, ly);
      csr_write(REG_MIN_Z, lz);
      csr_write(REG_MAX_X, hx);
      csr_write(REG_MAX_Y, hy);
      csr_write(REG_MAX_Z, hz);
      csr_write(REG_SURFACE_MODE, {31'd0, surf});
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_upper(logic [31:0] lower);
      logic [31:0] span, upper;
      span = $urandom_range(0, 32'h0040_0000);
      case ($urandom_range(0, 7))
         0: return lower;
         1: return random_coord();
         2: span = $urandom;
         default: ;
      endcase
      upper = lower + span;
      if ($signed(upper) < $signed(lower)) upper = 32'h7FFF_FFFF;
      return upper;
   endfunction

   function automatic logic [15:0] random_frac();
      case ($urandom_range(0, 15))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] lx, ly, lz;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset box: unit cube, volume
      push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      drain_results();

      apply_box(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
      push_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'h1234);
      push_sample(16'd10922, 16'h8000, 16'h0001, 16'h0000);
      push_sample(16'd10923, 16'h0001, 16'h8000, 16'h0000);
      push_sample(16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF);
      push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain_results();

      apply_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      push_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain_results();
      csr_write(REG_SURFACE_MODE, 32'd1);
      push_sample(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
      push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain_results();

      // reversed x: only the x faces carry area
      apply_box(32'h0003_0000, 32'hFFFE_0000, 32'h0000_0000,
                32'hFFFF_0000, 32'h0001_8000, 32'h0002_0000, 1'b1);
      push_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
      push_sample(16'hFFFF, 16'h8000, 16'h8000, 16'h0000);
      drain_results();
      csr_write(REG_SURFACE_MODE, 32'd0);
      push_sample(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain_results();

      // flat z: only the z faces carry area
      apply_box(32'hFFFF_0000, 32'h0000_4000, 32'h0005_0000,
                32'h0002_0000, 32'h0003_0000, 32'h0005_0000, 1'b1);
      push_sample(16'h0000, 16'h1111, 16'hEEEE, 16'h0000);
      push_sample(16'hFFFF, 16'hEEEE, 16'h1111, 16'h0000);
      drain_results();

      // zero total area: a point, then a line
      apply_box(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
      push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      drain_results();
      csr_write(REG_MAX_X, 32'h0009_0000);
      push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_gap_pct = 30; rsp_stall_pct = 30; end
            2: begin req_gap_pct = 60; rsp_stall_pct = 10; end
            default: begin req_gap_pct = 10; rsp_stall_pct = 60; end
         endcase
         lx = random_coord();
         ly = random_coord();
         lz = random_coord();
         apply_box(lx, ly, lz, random_upper(lx), random_upper(ly), random_upper(lz),
                   (phase % 3) != 0);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            push_sample(random_frac(), random_frac(), random_frac(), random_frac());
            // hold the sender until the pipeline is empty, then resume
            if (phase == 3 && n == PHASE_WORDS / 2) drain_results();
            if (pending_samples.size() > 8) begin
               while (pending_samples.size() > 2) @(posedge clock);
            end
         end
         drain_results();
      end

      drain_results();
      if (expected_points.size() != 0) begin
         report_mismatch("expectations left over", 32'(expected_points.size()), 32'd0);
      end
      if (mismatch_count == 0) begin
         $display("tb_box_point_sampler_core OK");
      end else begin
         $display("tb_box_point_sampler_core NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bps_pkg.sv
rtl/bps_csr.sv
rtl/bps_front.sv
rtl/bps_queue.sv
rtl/bps_back.sv
rtl/box_point_sampler_core.sv
test/tb_box_point_sampler_core.sv
